// ===== rtl/core/tdtes_pkg.sv =====
// Shared types, constants and tables for the date text to epoch seconds unit.
`timescale 1ns / 1ps
package tdtes_pkg;

	localparam int YEAR_MIN         = 1970;
	localparam int YEAR_MAX         = 3000;
	localparam int NUMBER_MAX       = 9999;
	localparam int DAY_MAX          = 31;
	localparam int YEAR_CHARS       = 4;
	localparam int TOKEN_LEN_MAX    = 5;
	localparam int TOKEN_KEEP       = 3;
	localparam int SECONDS_PER_DAY  = 86400;
	// x / 100 == (x * 5243) >> 19 for all x below 43699
	localparam int RECIP_100        = 5243;
	localparam int RECIP_100_SHIFT  = 19;
	// leap days in 1..1969
	localparam int LEAPS_BEFORE_MIN = 477;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_MISSING = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
	} date_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DAYS,
		ST_SECS,
		ST_OUT
	} back_state_t;

	// lowercase three-letter abbreviation to month number, 0 when no match
	function automatic logic [3:0] month_code(input logic [23:0] letters);
		logic [3:0] m;
		case (letters)
			"jan": m = 4'd1;
			"feb": m = 4'd2;
			"mar": m = 4'd3;
			"apr": m = 4'd4;
			"may": m = 4'd5;
			"jun": m = 4'd6;
			"jul": m = 4'd7;
			"aug": m = 4'd8;
			"sep": m = 4'd9;
			"oct": m = 4'd10;
			"nov": m = 4'd11;
			"dec": m = 4'd12;
			default: m = 4'd0;
		endcase
		return m;
	endfunction

	function automatic logic [8:0] days_before_month(input logic [3:0] month);
		logic [8:0] d;
		case (month)
			4'd1:  d = 9'd0;
			4'd2:  d = 9'd31;
			4'd3:  d = 9'd59;
			4'd4:  d = 9'd90;
			4'd5:  d = 9'd120;
			4'd6:  d = 9'd151;
			4'd7:  d = 9'd181;
			4'd8:  d = 9'd212;
			4'd9:  d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/tdtes_front.sv =====
// Tokenizer: takes characters, tracks month, day and year, pushes a date at end of text.
`timescale 1ns / 1ps
module tdtes_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [7:0]            character,
	input  logic                  queue_full,
	output logic                  push,
	output tdtes_pkg::date_t      push_data
);
	import tdtes_pkg::*;

	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [13:0] year_q;
	logic [2:0]  tok_len_q;
	logic [7:0]  tok_letters_q [TOKEN_KEEP];
	logic        tok_alpha_q;
	logic [13:0] tok_num_q;
	logic        digits_ended_q;

	logic        accept;
	logic        is_upper;
	logic        is_letter;
	logic        is_digit;
	logic [7:0]  lower_char;
	logic        char_step;
	logic        close_step;
	logic        eff_alpha;
	logic [16:0] num_next;
	logic [3:0]  match_month;
	logic [3:0]  close_month;
	logic [4:0]  close_day;
	logic [13:0] close_year;

	assign in_ready  = !command || !queue_full;
	assign accept    = in_valid && in_ready;
	assign is_upper  = (character >= "A") && (character <= "Z");
	assign is_letter = is_upper || ((character >= "a") && (character <= "z"));
	assign is_digit  = (character >= "0") && (character <= "9");
	assign lower_char = is_upper ? character + 8'd32 : character;

	assign char_step  = accept && !command && (is_letter || is_digit);
	assign close_step = accept && (command || !(is_letter || is_digit));

	// first character of a token decides whether it is alphabetic
	assign eff_alpha = (tok_len_q == 3'd0) ? is_letter : tok_alpha_q;
	assign num_next  = 17'(tok_num_q) * 17'd10 + 17'(character - "0");

	assign match_month = month_code({tok_letters_q[0], tok_letters_q[1], tok_letters_q[2]});

	always_comb begin
		close_month = month_q;
		close_day   = day_q;
		close_year  = year_q;
		if (tok_len_q != 3'd0) begin
			if (tok_alpha_q) begin
				if (tok_len_q >= 3'(TOKEN_KEEP) && match_month != 4'd0)
					close_month = match_month;
			end else if (tok_len_q == 3'(YEAR_CHARS)) begin
				close_year = tok_num_q;
			end else if (tok_num_q >= 14'd1 && tok_num_q <= 14'(DAY_MAX)) begin
				close_day = tok_num_q[4:0];
			end
		end
	end

	assign push            = accept && command;
	assign push_data.month = close_month;
	assign push_data.day   = close_day;
	assign push_data.year  = close_year;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q        <= '0;
			day_q          <= '0;
			year_q         <= '0;
			tok_len_q      <= '0;
			tok_alpha_q    <= 1'b0;
			tok_num_q      <= '0;
			digits_ended_q <= 1'b0;
			for (int i = 0; i < TOKEN_KEEP; i++)
				tok_letters_q[i] <= '0;
		end else if (close_step) begin
			if (command) begin
				month_q <= '0;
				day_q   <= '0;
				year_q  <= '0;
			end else begin
				month_q <= close_month;
				day_q   <= close_day;
				year_q  <= close_year;
			end
			tok_len_q      <= '0;
			tok_alpha_q    <= 1'b0;
			tok_num_q      <= '0;
			digits_ended_q <= 1'b0;
			for (int i = 0; i < TOKEN_KEEP; i++)
				tok_letters_q[i] <= '0;
		end else if (char_step) begin
			tok_alpha_q <= eff_alpha;
			for (int i = 0; i < TOKEN_KEEP; i++) begin
				if (tok_len_q == 3'(i))
					tok_letters_q[i] <= lower_char;
			end
			if (!eff_alpha && !digits_ended_q) begin
				if (is_digit) begin
					if (num_next > 17'(NUMBER_MAX))
						tok_num_q <= 14'(NUMBER_MAX);
					else
						tok_num_q <= num_next[13:0];
				end else begin
					digits_ended_q <= 1'b1;
				end
			end
			if (tok_len_q < 3'(TOKEN_LEN_MAX))
				tok_len_q <= tok_len_q + 3'd1;
		end
	end

endmodule

// ===== rtl/core/tdtes_queue.sv =====
// Short FIFO of finished dates between tokenizer and converter.
`timescale 1ns / 1ps
module tdtes_queue #(
	parameter int Depth = tdtes_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tdtes_pkg::date_t push_data,
	input  logic             pop,
	output tdtes_pkg::date_t pop_data,
	output logic             full,
	output logic             empty
);
	import tdtes_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	date_t            mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CntW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CntW'(1);
		end
	end

endmodule

// ===== rtl/core/tdtes_back.sv =====
// Converter: turns one date into status and seconds since 1970 through a sequence of states.
`timescale 1ns / 1ps
module tdtes_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             queue_empty,
	input  tdtes_pkg::date_t pop_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [34:0]      epoch_seconds
);
	import tdtes_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	date_t       rec_q;
	logic [6:0]  pq100_q;
	logic [6:0]  yq100_q;
	logic [1:0]  status_q;
	logic [18:0] days_q;
	logic [34:0] epoch_q;

	logic [13:0] prev_year;
	logic [26:0] prod_p;
	logic [26:0] prod_y;
	logic [1:0]  status_d;
	logic [13:0] y100;
	logic        div100;
	logic        leap;
	logic        leap_add;
	logic [10:0] year_off;
	logic [19:0] days20;
	logic [35:0] secs_prod;

	assign prev_year = rec_q.year - 14'd1;
	assign prod_p    = 27'(prev_year) * 27'(RECIP_100);
	assign prod_y    = 27'(rec_q.year) * 27'(RECIP_100);

	always_comb begin
		if (rec_q.month == 4'd0 || rec_q.day == 5'd0 || rec_q.year == 14'd0)
			status_d = STATUS_MISSING;
		else if (rec_q.year < 14'(YEAR_MIN) || rec_q.year > 14'(YEAR_MAX))
			status_d = STATUS_RANGE;
		else
			status_d = STATUS_OK;
	end

	// Gregorian leap rule from the registered quotient by 100
	assign y100     = 14'(yq100_q) * 14'd100;
	assign div100   = (rec_q.year == y100);
	assign leap     = (rec_q.year[1:0] == 2'd0 && !div100) || (div100 && yq100_q[1:0] == 2'd0);
	assign leap_add = (rec_q.month >= 4'd3) && leap;
	assign year_off = 11'(rec_q.year - 14'(YEAR_MIN));

	// only meaningful when the status is ok; other values are masked later
	assign days20 = 20'(year_off) * 20'd365
	              + 20'(prev_year[13:2]) + 20'(pq100_q[6:2]) - 20'(pq100_q)
	              - 20'(LEAPS_BEFORE_MIN)
	              + 20'(days_before_month(rec_q.month)) + 20'(leap_add)
	              + 20'(rec_q.day) - 20'd1;

	assign secs_prod = 36'(days_q) * 36'(SECONDS_PER_DAY);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (!queue_empty) state_d = ST_DIV;
			ST_DIV:  state_d = ST_DAYS;
			ST_DAYS: state_d = ST_SECS;
			ST_SECS: state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: pop = !queue_empty;
			ST_OUT:  out_valid = 1'b1;
			default: begin
				pop       = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= pop_data;
		if (state_q == ST_DIV) begin
			pq100_q  <= prod_p[RECIP_100_SHIFT +: 7];
			yq100_q  <= prod_y[RECIP_100_SHIFT +: 7];
			status_q <= status_d;
		end
		if (state_q == ST_DAYS)
			days_q <= days20[18:0];
		if (state_q == ST_SECS)
			epoch_q <= (status_q == STATUS_OK) ? secs_prod[34:0] : '0;
	end

	assign status        = status_q;
	assign epoch_seconds = epoch_q;

endmodule

// ===== rtl/core/text_date_to_epoch_seconds_unit.sv =====
// Top level of the date text to epoch seconds unit.
`timescale 1ns / 1ps
// Characters of a date text enter one per cycle with command low; any byte that is
// not an ASCII letter or digit separates tokens. Command high marks the end of the
// text: the pending token is closed, the collected month, day and year go into a
// queue of QueueDepth dates, and the tokenizer starts over at once. Characters never
// stall; an end marker waits only while the queue is full. A separate converter
// takes one date at a time and steps through dequeue, quotient by 100 through a
// reciprocal multiply, day count, multiply by 86400 and output, which waits for
// ready before the next date is taken. Status is 0 for a valid date, 1 when
// month, day or year is missing, 2 for a year outside 1970..3000; epoch_seconds is
// zero unless status is 0. Days past the end of a month roll into the next month.
module text_date_to_epoch_seconds_unit #(
	parameter int QueueDepth = tdtes_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [34:0] epoch_seconds
);
	import tdtes_pkg::*;

	date_t push_data;
	date_t pop_data;
	logic  push;
	logic  pop;
	logic  queue_full;
	logic  queue_empty;

	tdtes_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.character  (character),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	tdtes_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	tdtes_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (queue_empty),
		.pop_data      (pop_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.epoch_seconds (epoch_seconds)
	);

endmodule
